// ===== sv/mnet_pkg.sv =====
// shared types and constants for the midi note event tagger
`timescale 1ns / 1ps

package mnet_pkg;

  // note table size and hold limit
  localparam int          NOTE_COUNT    = 128;
  localparam int          NOTE_W        = $clog2(NOTE_COUNT);
  localparam logic [5:0]  MAX_HELD      = 6'd63;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1200;

  // status byte high nibbles
  localparam logic [3:0] STAT_OFF   = 4'h8;
  localparam logic [3:0] STAT_ON    = 4'h9;
  localparam logic [3:0] STAT_CTRL  = 4'hB;
  localparam logic [3:0] STAT_PROG  = 4'hC;
  localparam logic [3:0] STAT_PRESS = 4'hD;
  localparam logic [3:0] STAT_BEND  = 4'hE;

  // channel reported on flush note offs
  localparam logic [4:0] FLUSH_CHAN = 5'd1;

  // word widths on the stream ports
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 200;
  localparam int OUT_USER_W = 4;

  typedef enum logic [2:0] {
    KIND_ON    = 3'd0,
    KIND_OFF   = 3'd1,
    KIND_CTRL  = 3'd2,
    KIND_PROG  = 3'd3,
    KIND_PRESS = 3'd4,
    KIND_BEND  = 3'd5
  } kind_t;

  // decoded message handed from front to back
  typedef struct packed {
    logic [31:0] t;
    logic        has_evt;
    kind_t       kind;
    logic [4:0]  chan;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [13:0] bend;
  } cmd_t;

  // one tagged event on the result side
  typedef struct packed {
    logic [31:0] event_number;
    logic [31:0] note_serial;
    logic [31:0] event_time;
    logic [31:0] delay_ms;
    logic [4:0]  channel;
    kind_t       kind;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [31:0] block_number;
    logic        flushed;
    logic [13:0] pitch_bend;
    logic        last;
  } evt_t;

endpackage

// ===== sv/mnet_front.sv =====
// front end: picks the message bytes and classifies the status
`timescale 1ns / 1ps

module mnet_front import mnet_pkg::*; (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  output logic                 push_valid,
  input  logic                 push_ready,
  output cmd_t                 push_cmd
);

  logic [7:0]  byte0, byte1, byte2, byte3;
  logic [3:0]  msg_len;
  logic [31:0] time_ms;
  logic [7:0]  st, d1, d2;

  // unpack the input word
  assign byte0   = in_tdata[7:0];
  assign byte1   = in_tdata[15:8];
  assign byte2   = in_tdata[23:16];
  assign byte3   = in_tdata[31:24];
  assign msg_len = in_tdata[35:32];
  assign time_ms = in_tdata[67:36];

  // a word is taken whenever the queue has room; short messages are dropped
  assign in_tready  = push_ready;
  assign push_valid = in_tvalid && (msg_len >= 4'd3);

  // usb packets carry a leading header byte
  always_comb begin
    if (msg_len == 4'd3) begin
      st = byte0;
      d1 = byte1;
      d2 = byte2;
    end else begin
      st = byte1;
      d1 = byte2;
      d2 = byte3;
    end
  end

  // status decode
  always_comb begin
    push_cmd         = '0;
    push_cmd.t       = time_ms;
    push_cmd.chan    = {1'b0, st[3:0]} + 5'd1;
    push_cmd.has_evt = 1'b1;
    push_cmd.kind    = KIND_CTRL;
    case (st[7:4])
      STAT_CTRL: begin
        push_cmd.kind = KIND_CTRL;
        push_cmd.note = d1[6:0];
        push_cmd.vel  = d2[6:0];
      end
      STAT_PROG: begin
        push_cmd.kind = KIND_PROG;
        push_cmd.note = d1[6:0];
      end
      STAT_PRESS: begin
        push_cmd.kind = KIND_PRESS;
        push_cmd.vel  = d1[6:0];
      end
      STAT_BEND: begin
        push_cmd.kind = KIND_BEND;
        push_cmd.bend = {d2[6:0], d1[6:0]};
      end
      STAT_ON: begin
        push_cmd.kind = (d2 != 8'd0) ? KIND_ON : KIND_OFF;
        push_cmd.note = d1[6:0];
        push_cmd.vel  = d2[6:0];
      end
      STAT_OFF: begin
        push_cmd.kind = KIND_OFF;
        push_cmd.note = d1[6:0];
        push_cmd.vel  = d2[6:0];
      end
      default: begin
        push_cmd.has_evt = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/mnet_queue.sv =====
// small command queue between front and back
`timescale 1ns / 1ps

module mnet_queue import mnet_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/mnet_back.sv =====
// back end: timeout flush walk, held-note table and event tagging
`timescale 1ns / 1ps

module mnet_back import mnet_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  input  logic [15:0] hold_timeout,
  output logic        out_valid,
  input  logic        out_ready,
  output evt_t        out_evt
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SCAN  = 6'b000100,
    S_FLUSH = 6'b001000,
    S_READ  = 6'b010000,
    S_EVENT = 6'b100000
  } state_t;

  typedef struct packed {
    logic [31:0] block;
    logic [31:0] serial;
  } held_t;

  state_t                  state_r, state_nxt;
  cmd_t                    cur_r, cur_nxt;
  logic [NOTE_W-1:0]       idx_r, idx_nxt;
  logic [NOTE_COUNT-1:0]   held_map_r, held_map_nxt;
  logic [5:0]              held_cnt_r, held_cnt_nxt;
  logic [31:0]             evt_cnt_r, evt_cnt_nxt;
  logic [31:0]             next_serial_r, next_serial_nxt;
  logic [31:0]             next_block_r, next_block_nxt;
  logic [31:0]             cur_block_r, cur_block_nxt;
  logic [31:0]             prev_time_r, prev_time_nxt;
  logic [31:0]             last_on_r, last_on_nxt;
  logic [31:0]             last_off_r, last_off_nxt;
  logic                    out_valid_r, out_valid_nxt;
  evt_t                    out_r, out_nxt;

  // held serial and block per note
  held_t                   held_mem [NOTE_COUNT];
  held_t                   mem_rd_r;
  logic                    mem_we, mem_re;
  logic [NOTE_W-1:0]       mem_addr;
  held_t                   mem_wdata;

  logic                    out_free;
  logic [31:0]             act_time, age, delay, on_blk;
  logic                    timed_out;

  assign out_valid = out_valid_r;
  assign out_evt   = out_r;
  assign out_free  = !out_valid_r || out_ready;

  // timeout check against the latest note activity
  assign act_time  = (last_off_r > last_on_r) ? last_off_r : last_on_r;
  assign age       = cur_r.t - act_time;
  assign timed_out = (held_cnt_r != 6'd0) && (act_time != 32'd0) &&
                     (age >= {16'd0, hold_timeout});
  assign delay     = (evt_cnt_r == 32'd0) ? 32'd0 : cur_r.t - prev_time_r;
  assign on_blk    = (held_cnt_r == 6'd0) ? next_block_r : cur_block_r;

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    idx_nxt         = idx_r;
    held_map_nxt    = held_map_r;
    held_cnt_nxt    = held_cnt_r;
    evt_cnt_nxt     = evt_cnt_r;
    next_serial_nxt = next_serial_r;
    next_block_nxt  = next_block_r;
    cur_block_nxt   = cur_block_r;
    prev_time_nxt   = prev_time_r;
    last_on_nxt     = last_on_r;
    last_off_nxt    = last_off_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_nxt         = out_r;
    cmd_ready       = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_addr        = cur_r.note;
    mem_wdata       = '0;

    case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cur_nxt   = cmd;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (timed_out) begin
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_READ;
        end
      end

      // walk the table up to the next held note
      S_SCAN: begin
        if (held_map_r[idx_r]) begin
          mem_re    = 1'b1;
          mem_addr  = idx_r;
          state_nxt = S_FLUSH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // emit a flush note off for the held note at idx
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt              = '0;
          out_nxt.event_number = evt_cnt_r + 32'd1;
          out_nxt.note_serial  = mem_rd_r.serial;
          out_nxt.event_time   = cur_r.t;
          out_nxt.delay_ms     = delay;
          out_nxt.channel      = FLUSH_CHAN;
          out_nxt.kind         = KIND_OFF;
          out_nxt.note         = idx_r;
          out_nxt.block_number = mem_rd_r.block;
          out_nxt.flushed      = 1'b1;
          out_nxt.last         = (held_cnt_r == 6'd1) && !cur_r.has_evt;
          evt_cnt_nxt          = evt_cnt_r + 32'd1;
          prev_time_nxt        = cur_r.t;
          held_map_nxt[idx_r]  = 1'b0;
          held_cnt_nxt         = held_cnt_r - 6'd1;
          idx_nxt              = idx_r + 1'b1;
          if (held_cnt_r == 6'd1) begin
            cur_block_nxt = '0;
            last_on_nxt   = '0;
            last_off_nxt  = '0;
            state_nxt     = S_READ;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_READ: begin
        mem_re    = 1'b1;
        mem_addr  = cur_r.note;
        state_nxt = S_EVENT;
      end

      // the message's own event
      S_EVENT: begin
        if (!cur_r.has_evt) begin
          prev_time_nxt = cur_r.t;
          state_nxt     = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt              = '0;
          out_nxt.event_number = evt_cnt_r + 32'd1;
          out_nxt.event_time   = cur_r.t;
          out_nxt.delay_ms     = delay;
          out_nxt.channel      = cur_r.chan;
          out_nxt.kind         = cur_r.kind;
          out_nxt.note         = cur_r.note;
          out_nxt.velocity     = cur_r.vel;
          out_nxt.pitch_bend   = cur_r.bend;
          out_nxt.block_number = cur_block_r;
          out_nxt.last         = 1'b1;
          evt_cnt_nxt          = evt_cnt_r + 32'd1;
          prev_time_nxt        = cur_r.t;

          if (cur_r.kind == KIND_ON) begin
            out_nxt.note_serial  = next_serial_r;
            out_nxt.block_number = on_blk;
            next_serial_nxt      = next_serial_r + 32'd1;
            cur_block_nxt        = on_blk;
            if (held_cnt_r == 6'd0) begin
              next_block_nxt = next_block_r + 32'd1;
            end
            mem_wdata.block  = on_blk;
            mem_wdata.serial = next_serial_r;
            if (held_map_r[cur_r.note]) begin
              mem_we = 1'b1;
            end else if (held_cnt_r < MAX_HELD) begin
              mem_we                     = 1'b1;
              held_map_nxt[cur_r.note]   = 1'b1;
              held_cnt_nxt               = held_cnt_r + 6'd1;
            end
            last_on_nxt = cur_r.t;
          end else if (cur_r.kind == KIND_OFF) begin
            if (held_map_r[cur_r.note]) begin
              out_nxt.note_serial      = mem_rd_r.serial;
              out_nxt.block_number     = mem_rd_r.block;
              held_map_nxt[cur_r.note] = 1'b0;
              held_cnt_nxt             = held_cnt_r - 6'd1;
            end
            last_off_nxt = cur_r.t;
          end

          // table emptied by a note message closes the chord block
          if ((cur_r.kind == KIND_ON || cur_r.kind == KIND_OFF) &&
              held_cnt_nxt == 6'd0) begin
            cur_block_nxt = '0;
            last_on_nxt   = '0;
            last_off_nxt  = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      idx_r         <= '0;
      held_map_r    <= '0;
      held_cnt_r    <= '0;
      evt_cnt_r     <= '0;
      next_serial_r <= 32'd1;
      next_block_r  <= 32'd1;
      cur_block_r   <= '0;
      prev_time_r   <= '0;
      last_on_r     <= '0;
      last_off_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      held_map_r    <= held_map_nxt;
      held_cnt_r    <= held_cnt_nxt;
      evt_cnt_r     <= evt_cnt_nxt;
      next_serial_r <= next_serial_nxt;
      next_block_r  <= next_block_nxt;
      cur_block_r   <= cur_block_nxt;
      prev_time_r   <= prev_time_nxt;
      last_on_r     <= last_on_nxt;
      last_off_r    <= last_off_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  // held-note memory, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      held_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_r <= held_mem[mem_addr];
    end
  end

endmodule

// ===== sv/midi_note_event_tagger.sv =====
// top level of the midi note event tagger
`timescale 1ns / 1ps

// Takes one timestamped MIDI message per input word and returns tagged events.
// Input stream in_*: one word per message (bytes, length, arrival time).
// Output stream out_*: one word per event; out_tlast marks the last event of a
// message. Messages shorter than three bytes give no event; one with an unknown
// status gives no event of its own. Config write cfg_*: sets the note timeout in
// milliseconds; the port is always ready.
// The back end handles one message at a time in the steps pop, timeout check,
// table read and event, and takes the next message only once it is done. A
// timeout flush walks the 128-entry note table one entry per cycle up to the
// highest held note, emitting a flush note off for each held note it passes
// and waiting there while the output register is still full.
// A queue of QUEUE_DEPTH messages sits between decode and the back end, so
// the input keeps accepting while the back end works or waits.
// When the receiver stalls, the pending event holds in the output register
// and the back end waits; the input stops once the queue fills.
// Reset clears the held-note table, all counters and times, and loads the
// default timeout of 1200 ms; no clearing pass is needed.
module midi_note_event_tagger import mnet_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config write: hold timeout
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data,
  // input word
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // byte0, byte1, byte2, byte3, msg_length, time_ms, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // result word
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // event_number, note_serial, event_time, delay_ms, channel, note,
  // velocity, block_number, pitch_bend, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind, flushed
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  logic [15:0] hold_timeout_r;
  logic        push_valid, push_ready;
  cmd_t        push_cmd;
  logic        pop_valid, pop_ready;
  cmd_t        pop_cmd;
  evt_t        evt;

  // timeout register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_timeout_r <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      hold_timeout_r <= cfg_data;
    end
  end

  mnet_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  mnet_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  mnet_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (pop_valid),
    .cmd_ready    (pop_ready),
    .cmd          (pop_cmd),
    .hold_timeout (hold_timeout_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_evt      (evt)
  );

  // pack the result word
  assign out_tdata = {7'd0, evt.pitch_bend, evt.block_number, evt.velocity,
                      evt.note, evt.channel, evt.delay_ms, evt.event_time,
                      evt.note_serial, evt.event_number};
  assign out_tuser = {evt.flushed, evt.kind};
  assign out_tlast = evt.last;

endmodule

// ===== sim/tb.sv =====
// testbench for the midi note event tagger: directed table, random traffic, event checker
`timescale 1ns / 1ps

module tb import mnet_pkg::*; ();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD = 400;

  // one row of the directed table; n, kind..bend typed in only when typed is set
  typedef struct packed {
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [3:0]  len;
    logic [31:0] t;
    logic        typed;
    logic [1:0]  n;
    kind_t       kind;
    logic [4:0]  chan;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [13:0] bend;
  } stim_row_t;

  // directed rows, run at the reset timeout of 1200 ms
  localparam stim_row_t DIRECTED [26] = '{
    // short messages give nothing
    '{8'h90, 8'h3C, 8'h40, 8'h00, 4'd2, 32'd0, 1'b1, 2'd0, KIND_ON, 5'd0, 7'd0, 7'd0, 14'd0},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd0, 32'd5, 1'b1, 2'd0, KIND_ON, 5'd0, 7'd0, 7'd0, 14'd0},
    // one of each non-note kind, with pitch bend twice
    '{8'hB0, 8'h07, 8'h64, 8'h00, 4'd3, 32'd0, 1'b1, 2'd1, KIND_CTRL, 5'd1, 7'd7, 7'd100,
      14'd0},
    '{8'hC5, 8'h0A, 8'h55, 8'h00, 4'd3, 32'd10, 1'b1, 2'd1, KIND_PROG, 5'd6, 7'd10, 7'd0,
      14'd0},
    '{8'hDF, 8'h7F, 8'h33, 8'h00, 4'd3, 32'd20, 1'b1, 2'd1, KIND_PRESS, 5'd16, 7'd0, 7'd127,
      14'd0},
    '{8'hE0, 8'h7F, 8'h7F, 8'h00, 4'd3, 32'd30, 1'b1, 2'd1, KIND_BEND, 5'd1, 7'd0, 7'd0,
      14'h3FFF},
    '{8'hE3, 8'h00, 8'h00, 8'h00, 4'd3, 32'd40, 1'b1, 2'd1, KIND_BEND, 5'd4, 7'd0, 7'd0, 14'd0},
    // unknown status: data byte, poly aftertouch, system
    '{8'h45, 8'h12, 8'h34, 8'h00, 4'd3, 32'd50, 1'b1, 2'd0, KIND_ON, 5'd0, 7'd0, 7'd0, 14'd0},
    '{8'hA2, 8'h3C, 8'h40, 8'h00, 4'd3, 32'd60, 1'b1, 2'd0, KIND_ON, 5'd0, 7'd0, 7'd0, 14'd0},
    '{8'hF8, 8'h00, 8'h00, 8'h00, 4'd3, 32'd70, 1'b1, 2'd0, KIND_ON, 5'd0, 7'd0, 7'd0, 14'd0},
    // packet form, first byte skipped
    '{8'h09, 8'h90, 8'h3C, 8'h7F, 4'd4, 32'd100, 1'b1, 2'd1, KIND_ON, 5'd1, 7'd60, 7'd127,
      14'd0},
    // repeated note on with an out-of-range note byte
    '{8'h5A, 8'h91, 8'hBC, 8'h40, 4'd15, 32'd110, 1'b1, 2'd1, KIND_ON, 5'd2, 7'd60, 7'd64,
      14'd0},
    // raw velocity nonzero but zero after masking is still an on
    '{8'h90, 8'h40, 8'h80, 8'h00, 4'd3, 32'd120, 1'b1, 2'd1, KIND_ON, 5'd1, 7'd64, 7'd0,
      14'd0},
    // velocity zero note on counts as off
    '{8'h90, 8'h40, 8'h00, 8'h00, 4'd3, 32'd130, 1'b1, 2'd1, KIND_OFF, 5'd1, 7'd64, 7'd0,
      14'd0},
    '{8'h8F, 8'h3C, 8'hFF, 8'h00, 4'd3, 32'd140, 1'b1, 2'd1, KIND_OFF, 5'd16, 7'd60, 7'd127,
      14'd0},
    // off for a note that is not held
    '{8'h80, 8'h10, 8'h20, 8'h00, 4'd3, 32'd150, 1'b1, 2'd1, KIND_OFF, 5'd1, 7'd16, 7'd32,
      14'd0},
    '{8'h90, 8'h00, 8'h01, 8'h00, 4'd3, 32'd160, 1'b1, 2'd1, KIND_ON, 5'd1, 7'd0, 7'd1, 14'd0},
    '{8'h9F, 8'h7F, 8'h7F, 8'h00, 4'd3, 32'd170, 1'b1, 2'd1, KIND_ON, 5'd16, 7'd127, 7'd127,
      14'd0},
    // timeout flush of two held notes ahead of the control change
    '{8'hB1, 8'hFF, 8'hFF, 8'h00, 4'd3, 32'd2000, 1'b0, 2'd0, KIND_ON, 5'd0, 7'd0, 7'd0,
      14'd0},
    // note on at time zero leaves activity at zero, so no flush later
    '{8'h92, 8'h30, 8'h50, 8'h00, 4'd3, 32'd0, 1'b1, 2'd1, KIND_ON, 5'd3, 7'd48, 7'd80, 14'd0},
    '{8'hB0, 8'h01, 8'h02, 8'h00, 4'd3, 32'd50000, 1'b1, 2'd1, KIND_CTRL, 5'd1, 7'd1, 7'd2,
      14'd0},
    '{8'h80, 8'h30, 8'h00, 8'h00, 4'd3, 32'hFFFF_FFF0, 1'b1, 2'd1, KIND_OFF, 5'd1, 7'd48,
      7'd0, 14'd0},
    // timeout reached exactly across the time wrap
    '{8'hAA, 8'h90, 8'h11, 8'h22, 4'd4, 32'hFFFF_FFFF, 1'b1, 2'd1, KIND_ON, 5'd1, 7'd17,
      7'd34, 14'd0},
    '{8'hB0, 8'h05, 8'h06, 8'h00, 4'd3, 32'd1199, 1'b0, 2'd0, KIND_ON, 5'd0, 7'd0, 7'd0,
      14'd0},
    // one millisecond short of the timeout
    '{8'h90, 8'h22, 8'h01, 8'h00, 4'd3, 32'd1200, 1'b1, 2'd1, KIND_ON, 5'd1, 7'd34, 7'd1,
      14'd0},
    '{8'hB0, 8'h05, 8'h06, 8'h00, 4'd3, 32'd2399, 1'b1, 2'd1, KIND_CTRL, 5'd1, 7'd5, 7'd6,
      14'd0}
  };

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [15:0]           cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  // tagger state as predicted
  logic        held_on  [NOTE_COUNT];
  logic [31:0] held_blk [NOTE_COUNT];
  logic [31:0] held_ser [NOTE_COUNT];
  int          n_held;
  logic [31:0] evt_cnt, serial_next, block_next, block_cur, t_prev, t_on, t_off;
  logic [15:0] timeout_ms;

  // events still owed by the block, oldest first
  evt_t        pending_events [$];

  int          errors = 0;
  int          msgs_sent = 0;
  int          events_seen = 0;
  int          cycle_count = 0;
  logic [31:0] clock_ms = '0;

  midi_note_event_tagger i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic add_event(input logic [31:0] serial, t, delay, input logic [4:0] chan,
                           input kind_t kind, input logic [6:0] note, vel,
                           input logic [31:0] block, input logic flushed,
                           input logic [13:0] bend);
    evt_t e;
    e.event_number = evt_cnt;
    e.note_serial  = serial;
    e.event_time   = t;
    e.delay_ms     = delay;
    e.channel      = chan;
    e.kind         = kind;
    e.note         = note;
    e.velocity     = vel;
    e.block_number = block;
    e.flushed      = flushed;
    e.pitch_bend   = bend;
    e.last         = 1'b0;
    pending_events = {pending_events, e};
  endtask

  // predict the events of one accepted message
  task automatic tag_message(input logic [7:0] b0, b1, b2, b3, input logic [3:0] len,
                             input logic [31:0] t);
    logic [7:0]  st, d1, d2;
    logic [4:0]  chan;
    logic [6:0]  idx;
    logic [31:0] act, elapsed, gap_ms, serial, block;
    kind_t       k;
    evt_t        e;
    int          first;
    first = pending_events.size();
    if (len < 4'd3) return;
    if (len == 4'd3) {st, d1, d2} = {b0, b1, b2};
    else {st, d1, d2} = {b1, b2, b3};

    // timeout flush in ascending note order
    if (n_held != 0) begin
      act = (t_off > t_on) ? t_off : t_on;
      elapsed = t - act;
      if (act != 0 && elapsed >= {16'h0, timeout_ms}) begin
        for (int i = 0; i < NOTE_COUNT; i++) begin
          if (held_on[i]) begin
            evt_cnt++;
            add_event(held_ser[i], t, (evt_cnt == 32'd1) ? 32'd0 : t - t_prev, FLUSH_CHAN,
                      KIND_OFF, 7'(i), 7'd0, held_blk[i], 1'b1, 14'd0);
            t_prev = t;
            held_on[i] = 1'b0;
          end
        end
        n_held = 0;
        block_cur = '0;
        t_on = '0;
        t_off = '0;
      end
    end

    chan = 5'(st[3:0]) + 5'd1;
    gap_ms = (evt_cnt == 0) ? 32'd0 : t - t_prev;
    t_prev = t;
    case (st[7:4])
      STAT_CTRL: begin
        evt_cnt++;
        add_event('0, t, gap_ms, chan, KIND_CTRL, d1[6:0], d2[6:0], block_cur, 1'b0, 14'd0);
      end
      STAT_PROG: begin
        evt_cnt++;
        add_event('0, t, gap_ms, chan, KIND_PROG, d1[6:0], 7'd0, block_cur, 1'b0, 14'd0);
      end
      STAT_PRESS: begin
        evt_cnt++;
        add_event('0, t, gap_ms, chan, KIND_PRESS, 7'd0, d1[6:0], block_cur, 1'b0, 14'd0);
      end
      STAT_BEND: begin
        evt_cnt++;
        add_event('0, t, gap_ms, chan, KIND_BEND, 7'd0, 7'd0, block_cur, 1'b0,
                  {d2[6:0], d1[6:0]});
      end
      STAT_ON, STAT_OFF: begin
        idx = d1[6:0];
        serial = '0;
        block = block_cur;
        if (st[7:4] == STAT_ON && d2 != 8'd0) begin
          k = KIND_ON;
          serial = serial_next;
          serial_next++;
          if (n_held == 0) begin
            block_cur = block_next;
            block_next++;
          end
          block = block_cur;
          if (held_on[idx]) begin
            held_blk[idx] = block_cur;
            held_ser[idx] = serial;
          end else if (n_held < MAX_HELD) begin
            held_on[idx] = 1'b1;
            held_blk[idx] = block_cur;
            held_ser[idx] = serial;
            n_held++;
          end
          t_on = t;
        end else begin
          k = KIND_OFF;
          if (held_on[idx]) begin
            block = held_blk[idx];
            serial = held_ser[idx];
            held_on[idx] = 1'b0;
            n_held--;
          end
          t_off = t;
        end
        if (n_held == 0) begin
          block_cur = '0;
          t_on = '0;
          t_off = '0;
        end
        evt_cnt++;
        add_event(serial, t, gap_ms, chan, k, idx, d2[6:0], block, 1'b0, 14'd0);
      end
      default: ;
    endcase

    // mark the final event of this message
    if (pending_events.size() > first) begin
      e = pending_events[pending_events.size() - 1];
      e.last = 1'b1;
      pending_events[pending_events.size() - 1] = e;
    end
  endtask

  // offer one message word and predict once it is taken
  task automatic send_message(input logic [7:0] b0, b1, b2, b3, input logic [3:0] len,
                              input logic [31:0] t);
    int gap;
    gap = ((msgs_sent / 30) % 3 == 1) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {4'h0, t, len, b3, b2, b1, b0};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    msgs_sent++;
    tag_message(b0, b1, b2, b3, len, t);
  endtask

  // data byte, mostly 7-bit, now and then with the top bit set
  function automatic logic [7:0] data_byte();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
  endfunction

  // one random message: mostly well-formed traffic, some noise
  task automatic send_random();
    int          pick;
    int          held_list [$];
    logic [7:0]  st, d1, d2;
    logic [3:0]  len;
    pick = $urandom_range(0, 99);
    if (pick < 70) clock_ms += 32'($urandom_range(0, 400));
    else if (pick < 85) clock_ms += 32'($urandom_range(1000, 70000));
    else if (pick < 92) clock_ms = $urandom;
    else clock_ms += 32'($urandom_range(0, 3));

    d1 = data_byte();
    d2 = data_byte();
    len = ($urandom_range(0, 1) == 0) ? 4'd3 : 4'($urandom_range(4, 15));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      st = {STAT_ON, 4'($urandom)};
      if ($urandom_range(0, 3) != 0) d1 = 8'(36 + $urandom_range(0, 23));
    end else if (pick < 55) begin
      // release a held note where there is one
      for (int i = 0; i < NOTE_COUNT; i++) if (held_on[i]) held_list = {held_list, i};
      if (held_list.size() != 0)
        d1 = 8'(held_list[$urandom_range(0, held_list.size() - 1)]);
      if ($urandom_range(0, 1) == 0) st = {STAT_OFF, 4'($urandom)};
      else begin
        st = {STAT_ON, 4'($urandom)};
        d2 = 8'd0;
      end
    end else if (pick < 65) st = {STAT_CTRL, 4'($urandom)};
    else if (pick < 72) st = {STAT_PROG, 4'($urandom)};
    else if (pick < 78) st = {STAT_PRESS, 4'($urandom)};
    else if (pick < 86) st = {STAT_BEND, 4'($urandom)};
    else begin
      st = 8'($urandom);
      len = 4'($urandom);
    end

    if (len == 4'd3) send_message(st, d1, d2, 8'($urandom), len, clock_ms);
    else send_message(8'($urandom), st, d1, d2, len, clock_ms);
  endtask

  // let the block drain before touching the timeout register
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    timeout_ms = value;
  endtask

  // event checker with random stalls and one long hold-off
  initial begin : event_sink
    int   stall;
    logic long_done;
    evt_t got, want;
    long_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (events_seen == 70 && !long_done) begin
        long_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = ((events_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      events_seen++;

      got.event_number = out_tdata[31:0];
      got.note_serial  = out_tdata[63:32];
      got.event_time   = out_tdata[95:64];
      got.delay_ms     = out_tdata[127:96];
      got.channel      = out_tdata[132:128];
      got.note         = out_tdata[139:133];
      got.velocity     = out_tdata[146:140];
      got.block_number = out_tdata[178:147];
      got.pitch_bend   = out_tdata[192:179];
      got.kind         = kind_t'(out_tuser[2:0]);
      got.flushed      = out_tuser[3];
      got.last         = out_tlast;

      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("event %0d with none expected", got.event_number));
      end else begin
        want = pending_events[0];
        pending_events.delete(0);
        if (got.event_number !== want.event_number)
          report_mismatch($sformatf("event_number %0d, want %0d", got.event_number,
                                    want.event_number));
        if (got.note_serial !== want.note_serial)
          report_mismatch($sformatf("event %0d note_serial %0d, want %0d", want.event_number,
                                    got.note_serial, want.note_serial));
        if (got.event_time !== want.event_time)
          report_mismatch($sformatf("event %0d event_time %0d, want %0d", want.event_number,
                                    got.event_time, want.event_time));
        if (got.delay_ms !== want.delay_ms)
          report_mismatch($sformatf("event %0d delay_ms %0d, want %0d", want.event_number,
                                    got.delay_ms, want.delay_ms));
        if (got.channel !== want.channel)
          report_mismatch($sformatf("event %0d channel %0d, want %0d", want.event_number,
                                    got.channel, want.channel));
        if (got.kind !== want.kind)
          report_mismatch($sformatf("event %0d kind %0d, want %0d", want.event_number,
                                    got.kind, want.kind));
        if (got.note !== want.note)
          report_mismatch($sformatf("event %0d note %0d, want %0d", want.event_number,
                                    got.note, want.note));
        if (got.velocity !== want.velocity)
          report_mismatch($sformatf("event %0d velocity %0d, want %0d", want.event_number,
                                    got.velocity, want.velocity));
        if (got.block_number !== want.block_number)
          report_mismatch($sformatf("event %0d block_number %0d, want %0d", want.event_number,
                                    got.block_number, want.block_number));
        if (got.flushed !== want.flushed)
          report_mismatch($sformatf("event %0d flushed %0b, want %0b", want.event_number,
                                    got.flushed, want.flushed));
        if (got.pitch_bend !== want.pitch_bend)
          report_mismatch($sformatf("event %0d pitch_bend %0d, want %0d", want.event_number,
                                    got.pitch_bend, want.pitch_bend));
        if (got.last !== want.last)
          report_mismatch($sformatf("event %0d last %0b, want %0b", want.event_number,
                                    got.last, want.last));
      end
    end
  end

  // stimulus: directed table, then random phases at several timeouts
  initial begin : stimulus
    stim_row_t row;
    evt_t      e;
    int        first;

    // predicted state after reset
    for (int i = 0; i < NOTE_COUNT; i++) begin
      held_on[i] = 1'b0;
      held_blk[i] = '0;
      held_ser[i] = '0;
    end
    n_held = 0;
    evt_cnt = '0;
    serial_next = 32'd1;
    block_next = 32'd1;
    block_cur = '0;
    t_prev = '0;
    t_on = '0;
    t_off = '0;
    timeout_ms = TIMEOUT_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; typed rows replace the predicted kind and fields
    for (int r = 0; r < 26; r++) begin
      row = DIRECTED[r];
      first = pending_events.size();
      send_message(row.b0, row.b1, row.b2, row.b3, row.len, row.t);
      if (row.typed) begin
        while (pending_events.size() > first + int'(row.n)) void'(pending_events.pop_back());
        if (row.n == 2'd1 && pending_events.size() == first + 1) begin
          e = pending_events[first];
          e.kind = row.kind;
          e.channel = row.chan;
          e.note = row.note;
          e.velocity = row.vel;
          e.pitch_bend = row.bend;
          pending_events[first] = e;
        end
      end
    end
    clock_ms = 32'd5000;

    // zero timeout: any held note flushes on the next message
    wait_idle();
    write_timeout(16'd0);
    repeat (40) send_random();

    // longest timeout with the note table filled past its limit
    wait_idle();
    write_timeout(16'hFFFF);
    clock_ms += 32'd70000;
    for (int k = 0; k < 66; k++) begin
      clock_ms += 32'd1;
      send_message(8'($urandom), {STAT_ON, 4'($urandom)}, 8'(k),
                   8'($urandom_range(1, 127)), 4'd4, clock_ms);
    end
    clock_ms += 32'd70000;
    send_message({STAT_CTRL, 4'h0}, 8'd64, 8'd0, 8'h00, 4'd3, clock_ms);
    repeat (30) send_random();

    wait_idle();
    write_timeout(16'($urandom_range(1, 65534)));
    repeat (60) send_random();

    wait_idle();
    write_timeout(16'd300);
    repeat (60) send_random();

    // drain and finish
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mnet_pkg.sv
sv/mnet_front.sv
sv/mnet_queue.sv
sv/mnet_back.sv
sv/midi_note_event_tagger.sv
sim/tb.sv
